### src/nnbs_pkg.sv
// shared types and constants of the nearest-neighbor bitmap scaler
package nnbs_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 7;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = CFG_W'(320);
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = CFG_W'(200);
    localparam logic [CFG_W-1:0] RST_DST_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_DST_HEIGHT = CFG_W'(400);

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CNT_W-1:0] copies;
        logic [CNT_W-1:0] row_copies;
        logic             last_col;
        logic             err;
    } t_entry;

endpackage

### src/nnbs_in_if.sv
// source pixel channel
interface nnbs_in_if;
    import nnbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

### src/nnbs_out_if.sv
// destination pixel channel
interface nnbs_out_if;
    import nnbs_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic [CNT_W-1:0] row_copies;
    logic             last_copy;
    logic             end_of_line;
    logic             ratio_error;

    modport source (output valid, output pixel_out, output row_copies, output last_copy,
                    output end_of_line, output ratio_error, input ready);
    modport sink (input valid, input pixel_out, input row_copies, input last_copy,
                  input end_of_line, input ratio_error, output ready);
endinterface

### src/nnbs_div.sv
// restoring divider, one quotient bit per cycle
module nnbs_div #(
    parameter int W = 13
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quot;
    logic [W-1:0]  r_den;
    logic [W:0]    w_trial;
    logic          w_ge;
    logic [W-1:0]  n_rem;

    assign w_trial = {r_rem, r_quot[W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign n_rem   = w_ge ? W'(w_trial - {1'b0, r_den}) : W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_rem  <= '0;
                r_quot <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[W-2:0], w_ge};
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### src/nnbs_fifo.sv
// small entry queue between front and back
module nnbs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nnbs_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output nnbs_pkg::t_entry o_data,
    output logic            o_empty
);
    import nnbs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_data;
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_num <= r_num + NW'(1);
            end else if (!i_push && i_pop) begin
                r_num <= r_num - NW'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = r_num == NW'(DEPTH);
    assign o_empty = r_num == '0;

endmodule

### src/nnbs_front.sv
// front end: config registers, ratio division, accumulators and copy counts
module nnbs_front #(
    parameter int MAX_SCALE = 63,
    parameter int DIM_BITS  = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nnbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nnbs_pkg::CFG_W-1:0]      i_cfg_data,
    nnbs_in_if.sink                         i_in,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output nnbs_pkg::t_entry                o_q_data
);
    import nnbs_pkg::*;

    localparam int EW = DIM_BITS + 1;
    localparam int CW = (EW > CFG_W) ? EW : CFG_W;
    localparam int XW = (EW > CNT_W) ? EW : CNT_W;
    localparam int QW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE + 1) : 1;

    typedef enum logic {S_RUN, S_DIV} t_state;

    function automatic logic [EW-1:0] f_eff(input logic [CFG_W-1:0] v);
        logic [CW-1:0] x;
        logic [CW-1:0] top;
        x   = CW'(v);
        top = CW'(1) << DIM_BITS;
        if (x == '0) begin
            x = CW'(1);
        end else if (x > top) begin
            x = top;
        end
        return EW'(x);
    endfunction

    t_state              r_state;
    logic [EW-1:0]       r_sw, r_sh, r_dw, r_dh;
    logic [DIM_BITS-1:0] r_col_count, r_row_count;
    logic [DIM_BITS-1:0] r_col_accum, r_row_accum;
    logic [QW-1:0]       r_col_quot, r_row_quot;
    logic [DIM_BITS-1:0] r_col_rem, r_row_rem;
    logic [CNT_W-1:0]    r_cur_rc;
    logic                r_frame_err;
    logic                r_fresh;

    logic                w_cdone, w_rdone;
    logic [EW-1:0]       w_cquot, w_crem, w_rquot, w_rrem;
    logic                w_div_err;
    logic                w_cfg_hit;
    logic                w_fs, w_row_start, w_need_div, w_div_start, w_acc;
    logic [DIM_BITS-1:0] w_rbase, w_cbase;
    logic [EW-1:0]       w_rsum, w_csum;
    logic                w_rge, w_cge;
    logic [DIM_BITS-1:0] n_row_accum, n_col_accum;
    logic [CNT_W-1:0]    w_rn, w_cn, w_rc;
    logic                w_last_col, w_last_row;

    nnbs_div #(.W(EW)) u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_dw),
        .i_den   (r_sw),
        .o_done  (w_cdone),
        .o_quot  (w_cquot),
        .o_rem   (w_crem)
    );

    nnbs_div #(.W(EW)) u_row_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_dh),
        .i_den   (r_sh),
        .o_done  (w_rdone),
        .o_quot  (w_rquot),
        .o_rem   (w_rrem)
    );

    assign w_div_err = (XW'(w_cquot) > XW'(MAX_SCALE)) || (XW'(w_rquot) > XW'(MAX_SCALE));
    assign w_cfg_hit = i_cfg_we && (i_cfg_idx inside {CFG_SRC_WIDTH, CFG_SRC_HEIGHT,
                                                      CFG_DST_WIDTH, CFG_DST_HEIGHT});

    assign w_row_start = r_col_count == '0;
    assign w_fs        = w_row_start && (r_row_count == '0);
    assign w_need_div  = w_fs && !r_fresh;
    assign w_div_start = (r_state == S_RUN) && i_in.valid && w_need_div && !i_cfg_we;
    assign i_in.ready  = (r_state == S_RUN) && !w_need_div && !i_q_full;
    assign w_acc       = i_in.valid && i_in.ready;

    // row repeat count
    assign w_rbase     = w_fs ? '0 : r_row_accum;
    assign w_rsum      = EW'(w_rbase) + EW'(r_row_rem);
    assign w_rge       = w_rsum >= r_sh;
    assign n_row_accum = w_rge ? DIM_BITS'(w_rsum - r_sh) : DIM_BITS'(w_rsum);
    assign w_rn        = CNT_W'(r_row_quot) + CNT_W'(w_rge);
    assign w_rc        = (w_row_start && !r_frame_err) ? w_rn : r_cur_rc;

    // pixel copy count
    assign w_cbase     = w_row_start ? '0 : r_col_accum;
    assign w_csum      = EW'(w_cbase) + EW'(r_col_rem);
    assign w_cge       = w_csum >= r_sw;
    assign n_col_accum = w_cge ? DIM_BITS'(w_csum - r_sw) : DIM_BITS'(w_csum);
    assign w_cn        = CNT_W'(r_col_quot) + CNT_W'(w_cge);

    assign w_last_col  = (EW'(r_col_count) + EW'(1)) >= r_sw;
    assign w_last_row  = (EW'(r_row_count) + EW'(1)) >= r_sh;

    assign o_q_push            = w_acc;
    assign o_q_data.pix        = i_in.pixel_in;
    assign o_q_data.copies     = r_frame_err ? '0 : w_cn;
    assign o_q_data.row_copies = w_rc;
    assign o_q_data.last_col   = w_last_col;
    assign o_q_data.err        = r_frame_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_sw        <= f_eff(RST_SRC_WIDTH);
            r_sh        <= f_eff(RST_SRC_HEIGHT);
            r_dw        <= f_eff(RST_DST_WIDTH);
            r_dh        <= f_eff(RST_DST_HEIGHT);
            r_col_count <= '0;
            r_row_count <= '0;
            r_col_accum <= '0;
            r_row_accum <= '0;
            r_col_quot  <= '0;
            r_row_quot  <= '0;
            r_col_rem   <= '0;
            r_row_rem   <= '0;
            r_cur_rc    <= '0;
            r_frame_err <= 1'b0;
            r_fresh     <= 1'b0;
        end else if (w_cfg_hit) begin
            case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_sw <= f_eff(i_cfg_data);
                CFG_SRC_HEIGHT: r_sh <= f_eff(i_cfg_data);
                CFG_DST_WIDTH:  r_dw <= f_eff(i_cfg_data);
                CFG_DST_HEIGHT: r_dh <= f_eff(i_cfg_data);
                default: ;
            endcase
            r_state     <= S_RUN;
            r_col_count <= '0;
            r_row_count <= '0;
            r_col_accum <= '0;
            r_row_accum <= '0;
            r_fresh     <= 1'b0;
        end else begin
            case (r_state)
                S_RUN: begin
                    if (w_div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_cdone && w_rdone) begin
                        r_state     <= S_RUN;
                        r_fresh     <= 1'b1;
                        r_frame_err <= w_div_err;
                        if (!w_div_err) begin
                            r_col_quot <= QW'(w_cquot);
                            r_row_quot <= QW'(w_rquot);
                            r_col_rem  <= DIM_BITS'(w_crem);
                            r_row_rem  <= DIM_BITS'(w_rrem);
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
            if (w_acc) begin
                if (w_fs) begin
                    r_fresh <= 1'b0;
                end
                if (w_row_start) begin
                    r_row_accum <= r_frame_err ? w_rbase : n_row_accum;
                    r_cur_rc    <= w_rc;
                end
                r_col_accum <= r_frame_err ? w_cbase : n_col_accum;
                if (w_last_col) begin
                    r_col_count <= '0;
                    r_row_count <= w_last_row ? '0 : r_row_count + DIM_BITS'(1);
                end else begin
                    r_col_count <= r_col_count + DIM_BITS'(1);
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_col_count) < r_sw) else $error("column count out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_row_count) < r_sh) else $error("row count out of range");
    a_ratio_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_fs) |-> r_fresh) else $error("frame start taken without ratios");
    a_fresh_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_fs && !i_cfg_we) |=> !r_fresh) else $error("ratios not retired");
`endif

endmodule

### src/nnbs_back.sv
// back end: replays each queued pixel into its copies on the output
module nnbs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  nnbs_pkg::t_entry i_q_data,
    output logic             o_q_pop,
    nnbs_out_if.source       o_out
);
    import nnbs_pkg::*;

    logic             r_act;
    logic [CNT_W-1:0] r_left;
    t_entry           r_ent;
    logic             r_ovalid;
    logic [PIX_W-1:0] r_opix;
    logic [CNT_W-1:0] r_orc;
    logic             r_olast;
    logic             r_oeol;
    logic             r_oerr;

    logic             w_load, w_emit, w_fin, w_final;
    logic [CNT_W-1:0] w_qcnt;

    assign w_load  = !r_ovalid || o_out.ready;
    assign w_emit  = r_act && w_load;
    assign w_final = r_left == CNT_W'(1);
    assign w_fin   = w_emit && w_final;
    assign o_q_pop = !i_q_empty && (!r_act || w_fin);
    assign w_qcnt  = i_q_data.err ? CNT_W'(1) : i_q_data.copies;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_ent  <= i_q_data;
                r_left <= w_qcnt;
                r_act  <= w_qcnt != '0;
            end else if (w_fin) begin
                r_act <= 1'b0;
            end else if (w_emit) begin
                r_left <= r_left - CNT_W'(1);
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
                if (r_ent.err) begin
                    r_opix  <= '0;
                    r_orc   <= '0;
                    r_olast <= 1'b0;
                    r_oeol  <= 1'b0;
                    r_oerr  <= 1'b1;
                end else begin
                    r_opix  <= r_ent.pix;
                    r_orc   <= r_ent.row_copies;
                    r_olast <= w_final;
                    r_oeol  <= w_final && r_ent.last_col;
                    r_oerr  <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.pixel_out   = r_opix;
    assign o_out.row_copies  = r_orc;
    assign o_out.last_copy   = r_olast;
    assign o_out.end_of_line = r_oeol;
    assign o_out.ratio_error = r_oerr;

`ifndef ASSERT_OFF
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_left != '0)) else $error("active entry with no copies left");
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ratio_error) |-> (!o_out.last_copy && o_out.pixel_out == '0))
        else $error("error beat carries pixel data");
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.end_of_line) |-> o_out.last_copy)
        else $error("end of line on a non-final copy");
`endif

endmodule

### src/nearest_neighbor_bitmap_scaler.sv
// top level of the nearest-neighbor bitmap scaler
//
// i_in takes 8-bit source pixels in raster order, one beat per pixel.
// o_out gives destination pixels: each source pixel is repeated zero or
// more times along the line, each pixel beat carries the row repeat count,
// last_copy marks the final copy of a source pixel and end_of_line the
// final pixel of a destination line. If a scale ratio exceeds MAX_SCALE,
// every pixel of that frame gives a single beat with ratio_error set.
// Config writes (index 0..3: src_width, src_height, dst_width, dst_height)
// restart the frame; the user must make them only while the block is
// idle, which the block itself does not enforce. The first pixel of a
// frame waits for the two serial ratio dividers. After that a pixel enters
// per cycle while the queue has room; it passes through the queue and the
// entry register into the output register, which gives one beat per cycle.
// A stalled receiver holds the output register; the queue then fills and
// i_in.ready drops. Reset restores the default 320x200 to 640x400 setup.
module nearest_neighbor_bitmap_scaler #(
    parameter int MAX_SCALE = 63,
    parameter int DIM_BITS  = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [nnbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [nnbs_pkg::CFG_W-1:0]     i_cfg_data,
    nnbs_in_if.sink                        i_in,
    nnbs_out_if.source                     o_out
);
    import nnbs_pkg::*;

    logic   w_push, w_full, w_pop, w_empty;
    t_entry w_push_data, w_pop_data;

    nnbs_front #(
        .MAX_SCALE (MAX_SCALE),
        .DIM_BITS  (DIM_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_data   (w_push_data)
    );

    nnbs_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    nnbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_data  (w_pop_data),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );

endmodule

### verif/tb_nearest_neighbor_bitmap_scaler.sv
// testbench of the nearest-neighbor bitmap scaler with its own replication predictor
module tb_nearest_neighbor_bitmap_scaler;
    timeunit 1ns;
    timeprecision 1ps;

    import nnbs_pkg::*;

    localparam int          MAX_SCALE    = 63;
    localparam int          DIM_BITS     = 12;
    localparam int unsigned DIM_TOP      = 1 << DIM_BITS;
    localparam int          DRAIN_CYCLES = 2 * (DIM_BITS + 2) + FIFO_DEPTH + 8;
    localparam int          LIMIT_CYCLES = 3_000_000;
    localparam int          RANDOM_PIXELS = 400;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(5);

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [CNT_W-1:0] row_copies;
        logic             last_copy;
        logic             eol;
        logic             err;
    } t_px_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    nnbs_in_if  in_if ();
    nnbs_out_if out_if ();

    nearest_neighbor_bitmap_scaler #(
        .MAX_SCALE (MAX_SCALE),
        .DIM_BITS  (DIM_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [CFG_W-1:0] reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
    int unsigned      col_acc, row_acc, col_pos, row_pos;
    int unsigned      col_q, col_r, row_q, row_r;
    logic [CNT_W-1:0] row_reps;
    bit               frame_bad;

    t_px_beat expected_px[$];
    int       n_bad;
    int       n_cycles;
    bit       no_gaps;
    int       hold_req;
    int       hold_left;
    int       stall_left;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DIM_TOP)
            return DIM_TOP;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(9, 20);
    endfunction

    task automatic restart_frame();
        col_acc = 0;
        row_acc = 0;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic predict_copies(input logic [PIX_W-1:0] pix);
        int unsigned sw, sh, dw, dh, acc, n;
        bit          last_col;
        sw = clamp_dim(reg_src_w);
        sh = clamp_dim(reg_src_h);
        dw = clamp_dim(reg_dst_w);
        dh = clamp_dim(reg_dst_h);
        if (col_pos == 0 && row_pos == 0) begin
            frame_bad = (dw / sw > MAX_SCALE) || (dh / sh > MAX_SCALE);
            if (!frame_bad) begin
                col_q = dw / sw;
                col_r = dw % sw;
                row_q = dh / sh;
                row_r = dh % sh;
            end
            row_acc = 0;
        end
        if (col_pos == 0) begin
            col_acc = 0;
            if (!frame_bad) begin
                acc = row_acc + row_r;
                n   = row_q;
                if (acc >= sh) begin
                    acc -= sh;
                    n++;
                end
                row_acc  = acc;
                row_reps = n[CNT_W-1:0];
            end
        end
        last_col = (col_pos + 1 >= sw);
        if (frame_bad) begin
            expected_px.push_back('{'0, '0, 1'b0, 1'b0, 1'b1});
        end else begin
            acc = col_acc + col_r;
            n   = col_q;
            if (acc >= sw) begin
                acc -= sw;
                n++;
            end
            col_acc = acc;
            for (int k = 0; k < n; k++) begin
                expected_px.push_back('{pix, row_reps, k + 1 == n, (k + 1 == n) && last_col,
                                        1'b0});
            end
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= sh) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic report_bad(input string what, input t_px_beat want, input t_px_beat got);
        n_bad++;
        if (n_bad <= 10) begin
            $display("%0t %s: expected pix=%h rows=%0d last=%b eol=%b err=%b",
                     $realtime, what, want.pix, want.row_copies, want.last_copy, want.eol,
                     want.err);
            $display("    got pix=%h rows=%0d last=%b eol=%b err=%b",
                     got.pix, got.row_copies, got.last_copy, got.eol, got.err);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_px_beat got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.pixel_out, out_if.row_copies, out_if.last_copy,
                    out_if.end_of_line, out_if.ratio_error};
            if (expected_px.size() == 0) begin
                report_bad("beat with nothing expected", '0, got);
            end else begin
                want = expected_px.pop_front();
                if (got.pix !== want.pix || got.row_copies !== want.row_copies ||
                    got.last_copy !== want.last_copy || got.eol !== want.eol ||
                    got.err !== want.err) begin
                    report_bad("beat mismatch", want, got);
                end
            end
        end
    end

    // receiver pacing
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (no_gaps) begin
            out_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid    <= 1'b1;
        in_if.pixel_in <= pix;
        do @(posedge i_clk); while (!in_if.ready);
        predict_copies(pix);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(PIX_W'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        bit known;
        settle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        known = 1'b1;
        case (idx)
            CFG_SRC_WIDTH:  reg_src_w = val;
            CFG_SRC_HEIGHT: reg_src_h = val;
            CFG_DST_WIDTH:  reg_dst_w = val;
            CFG_DST_HEIGHT: reg_dst_h = val;
            default:        known = 1'b0;
        endcase
        if (known)
            restart_frame();
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                             input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'hAA);
        send_pixel(8'h55);
    endtask

    task automatic test_upscale_extremes();
        set_frame(1, 1, 63, 63);
        send_random(2);
        set_frame(2, 2, 127, 127);
        send_random(4);
    endtask

    task automatic test_ratio_error();
        set_frame(1, 1, 64, 1);
        send_random(2);
        write_reg(CFG_DST_WIDTH, 1);
        write_reg(CFG_DST_HEIGHT, 64);
        send_random(2);
        set_frame(0, 1, 8191, 1);
        send_random(1);
    endtask

    task automatic test_downscale_skip();
        set_frame(3, 2, 1, 1);
        send_random(6);
    endtask

    task automatic test_clamp_and_ignore();
        set_frame(3, 1, 6, 1);
        send_random(2);
        write_reg(CFG_SPARE_IDX, 13'h1FFF);
        send_random(1);
        set_frame(8191, 0, 4097, 0);
        send_random(2);
    endtask

    task automatic test_backpressure();
        set_frame(4, 2, 12, 6);
        @(posedge i_clk);
        no_gaps  = 1'b1;
        hold_req = 300;
        send_random(16);
        settle();
        no_gaps = 1'b0;
        send_random(8);
    endtask

    task automatic test_random_frames();
        int sent, kind, n, sw, sh, dw, dh;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            kind    = $urandom_range(0, 9);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (kind < 7) begin
                sw = $urandom_range(1, 8);
                sh = $urandom_range(1, 4);
                if (kind == 6) begin
                    dw = sw * $urandom_range(40, 64) + $urandom_range(0, sw - 1);
                    dh = sh * $urandom_range(1, 3);
                end else begin
                    dw = $urandom_range(1, sw * 5);
                    dh = $urandom_range(1, sh * 5);
                end
                set_frame(CFG_W'(sw), CFG_W'(sh), CFG_W'(dw), CFG_W'(dh));
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(1, sw * sh);
                else
                    n = sw * sh * $urandom_range(1, 2);
            end else if (kind < 9) begin
                set_frame(CFG_W'($urandom_range(0, 8191)), CFG_W'($urandom_range(0, 8191)),
                          CFG_W'($urandom_range(0, 8191)), CFG_W'($urandom_range(0, 8191)));
                n = $urandom_range(1, 6);
            end else begin
                write_reg(CFG_IDX_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 8191)));
                n = $urandom_range(1, 8);
            end
            send_random(n);
            sent += n;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.pixel_in  = '0;
        out_if.ready    = 1'b0;
        n_bad           = 0;
        n_cycles        = 0;
        no_gaps         = 1'b0;
        hold_req        = 0;
        hold_left       = 0;
        stall_left      = 0;
        reg_src_w       = RST_SRC_WIDTH;
        reg_src_h       = RST_SRC_HEIGHT;
        reg_dst_w       = RST_DST_WIDTH;
        reg_dst_h       = RST_DST_HEIGHT;
        restart_frame();
        col_q           = 0;
        col_r           = 0;
        row_q           = 0;
        row_r           = 0;
        row_reps        = '0;
        frame_bad       = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_upscale_extremes();
        test_ratio_error();
        test_downscale_skip();
        test_clamp_and_ignore();
        test_backpressure();
        test_random_frames();

        settle();
        if (expected_px.size() != 0)
            n_bad++;
        if (n_bad == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
src/nnbs_pkg.sv
src/nnbs_in_if.sv
src/nnbs_out_if.sv
src/nnbs_div.sv
src/nnbs_fifo.sv
src/nnbs_front.sv
src/nnbs_back.sv
src/nearest_neighbor_bitmap_scaler.sv
verif/tb_nearest_neighbor_bitmap_scaler.sv
